### design/hmm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hmm forward package
// shared types, codes and constants of the forward probability block
// ---------------------------------------------------------------------------
package hmm_pkg;

	localparam int MaxStatesDef  = 16;
	localparam int MaxSymbolsDef = 16;

	localparam logic [2:0] FUNC_LOAD_INIT  = 3'd0;
	localparam logic [2:0] FUNC_LOAD_TRANS = 3'd1;
	localparam logic [2:0] FUNC_LOAD_EMIT  = 3'd2;
	localparam logic [2:0] FUNC_LOAD_SYM   = 3'd3;
	localparam logic [2:0] FUNC_OBSERVE    = 3'd4;
	localparam logic [2:0] FUNC_FINISH     = 3'd5;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_RANGE   = 2'd1;
	localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

	localparam logic [0:0] REG_STATE_COUNT  = 1'b0;
	localparam logic [0:0] REG_SYMBOL_COUNT = 1'b1;

	localparam logic [15:0] ONE_Q15 = 16'h8000;
	localparam logic [32:0] ONE_Q31 = 33'h0_8000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_J_START,
		ST_RD,
		ST_MUL1,
		ST_MUL2,
		ST_ACC,
		ST_WRITE,
		ST_COPY,
		ST_SUM,
		ST_DONE
	} state_t;

	// control from sequencer to mac unit
	typedef struct packed {
		logic clear;
		logic mul1;
		logic mul2;
		logic acc;
		logic first;
	} mac_ctrl_t;

	// saturating add capped at one in Q1.31
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = (s > ONE_Q31) ? ONE_Q31[31:0] : s[31:0];
	endfunction

endpackage

### design/hmm_mac.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hmm multiply-accumulate unit
// one shared 32x16 multiplier reused for both product steps of each term after the first observation
// ---------------------------------------------------------------------------
module hmm_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  hmm_pkg::mac_ctrl_t ctrl,
	input  logic [31:0]       alpha,
	input  logic [15:0]       trans,
	input  logic [15:0]       emit,
	input  logic [15:0]       init,
	output logic [31:0]       acc
);
	import hmm_pkg::*;

	logic [31:0] op_a;
	logic [15:0] op_b;
	logic [47:0] prod;
	logic [32:0] term_q;
	logic [31:0] acc_q;

	always_comb begin
		op_a = ctrl.mul2 ? term_q[31:0] : alpha;
		op_b = ctrl.mul2 ? emit : trans;
		if (ctrl.first) begin
			op_a = {16'd0, init};
			op_b = emit;
		end
		prod = op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= '0;
			acc_q  <= '0;
		end else begin
			if (ctrl.clear) acc_q <= '0;
			if (ctrl.first && ctrl.mul1) begin
				term_q <= {prod[31:0], 1'b0};
			end else if (ctrl.mul1) begin
				term_q <= {1'b0, prod[46:15]};
			end else if (ctrl.mul2) begin
				// alpha*a>>15 is below 2^32, times e>>15 below 2^33
				term_q <= {prod[47:15]} > {15'd0, ONE_Q31} ? ONE_Q31 : prod[47:15];
			end
			if (ctrl.acc) acc_q <= sat_add(acc_q, term_q[31:0]);
		end
	end

	assign acc = acc_q;
endmodule

### design/hmm_forward_probability_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hmm forward probability top
// forward algorithm sequencer with tables, shared mac unit and result port
// ---------------------------------------------------------------------------
// loads and bad requests pass straight from idle to the done state and the registered result
// observe: symbol search, then per term read, multiply, a second multiply (skipped on the
// first observation) and accumulate, all through the single shared multiplier
// finish: sums the active forward values; busy stays high until the strobe, one request at a time
// done lasts one cycle and the receiver cannot stall
// reset sets the state count to 2 and symbol count to 4, clears forward values and sequence count; tables undefined
module hmm_forward_probability_top #(
	parameter int MAX_STATES  = hmm_pkg::MaxStatesDef,
	parameter int MAX_SYMBOLS = hmm_pkg::MaxSymbolsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [3:0]  row_index,
	input  logic [3:0]  col_index,
	input  logic [15:0] prob_value,
	input  logic [7:0]  char_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] total_prob,
	output logic [15:0] obs_count
);
	import hmm_pkg::*;

	localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int YW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int TW = (MAX_STATES * MAX_STATES > 1) ? $clog2(MAX_STATES * MAX_STATES) : 1;
	localparam int EW = (MAX_STATES * MAX_SYMBOLS > 1) ? $clog2(MAX_STATES * MAX_SYMBOLS) : 1;

	state_t state_q, state_d;

	logic [4:0]  state_count_q, symbol_count_q;
	logic [4:0]  ns, nsym;
	logic [15:0] init_mem [MAX_STATES];
	logic [15:0] trans_mem [MAX_STATES*MAX_STATES];
	logic [15:0] emit_mem [MAX_STATES*MAX_SYMBOLS];
	logic [7:0]  sym_q [MAX_SYMBOLS];
	logic [31:0] alpha_q [MAX_STATES];
	logic [31:0] next_q [MAX_STATES];
	logic [15:0] obs_q;

	logic [2:0]  func_q;
	logic [3:0]  row_q, col_q;
	logic [7:0]  char_q;

	logic [5:0]  j_q, k_q, s_q;
	logic [15:0] trans_s1, emit_s1, init_s1;
	logic [31:0] alpha_s1;
	logic [31:0] sum_q;
	mac_ctrl_t   ctrl;
	logic [31:0] acc;
	logic        first_q;
	logic        last_k;
	logic [1:0]  done_status;

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = !busy && !start;

	always_comb begin
		ns   = (int'(state_count_q) > MAX_STATES) ? 5'(MAX_STATES) : state_count_q;
		nsym = (int'(symbol_count_q) > MAX_SYMBOLS) ? 5'(MAX_SYMBOLS) : symbol_count_q;
	end

	assign last_k = ((k_q + 6'd1) >= 6'(ns)) || first_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (start) state_d = (func == FUNC_OBSERVE) ? ST_SEARCH
				: (func == FUNC_FINISH) ? ST_SUM : ST_DONE;
			ST_SEARCH: begin
				if (s_q >= 6'(nsym)) state_d = ST_DONE;
				else if (sym_q[s_q[YW-1:0]] == char_q) state_d = ST_J_START;
			end
			ST_J_START: state_d = (j_q >= 6'(ns)) ? ST_COPY : ST_RD;
			ST_RD:      state_d = ST_MUL1;
			ST_MUL1:    state_d = first_q ? ST_ACC : ST_MUL2;
			ST_MUL2:    state_d = ST_ACC;
			ST_ACC:     state_d = last_k ? ST_WRITE : ST_RD;
			ST_WRITE:   state_d = ST_J_START;
			ST_COPY:    state_d = ST_DONE;
			ST_SUM:     if (k_q >= 6'(ns)) state_d = ST_DONE;
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.first = first_q;
		case (state_q)
			ST_J_START: ctrl.clear = 1'b1;
			ST_MUL1:    ctrl.mul1 = 1'b1;
			ST_MUL2:    ctrl.mul2 = 1'b1;
			ST_ACC:     ctrl.acc = 1'b1;
			default:    ;
		endcase
	end

	always_comb begin
		done_status = STATUS_OK;
		case (func_q)
			FUNC_LOAD_INIT:
				if (5'(row_q) >= ns) done_status = STATUS_RANGE;
			FUNC_LOAD_TRANS:
				if (5'(row_q) >= ns || 5'(col_q) >= ns) done_status = STATUS_RANGE;
			FUNC_LOAD_EMIT:
				if (5'(row_q) >= ns || 5'(col_q) >= nsym) done_status = STATUS_RANGE;
			FUNC_LOAD_SYM:
				if (5'(col_q) >= nsym) done_status = STATUS_RANGE;
			FUNC_OBSERVE:
				if (s_q >= 6'(nsym)) done_status = STATUS_UNKNOWN;
			FUNC_FINISH:
				done_status = STATUS_OK;
			default: done_status = STATUS_RANGE;
		endcase
	end

	hmm_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.alpha (alpha_s1),
		.trans (trans_s1),
		.emit  (emit_s1),
		.init  (init_s1),
		.acc   (acc)
	);

	// tables, written on load requests in the idle cycle; operand registers loaded in the read state
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			case (func)
				FUNC_LOAD_INIT:
					if (5'(row_index) < ns)
						init_mem[SW'(row_index)] <= (prob_value > ONE_Q15) ? ONE_Q15 : prob_value;
				FUNC_LOAD_TRANS:
					if (5'(row_index) < ns && 5'(col_index) < ns)
						trans_mem[TW'(int'(row_index) * MAX_STATES + int'(col_index))] <=
							(prob_value > ONE_Q15) ? ONE_Q15 : prob_value;
				FUNC_LOAD_EMIT:
					if (5'(row_index) < ns && 5'(col_index) < nsym)
						emit_mem[EW'(int'(row_index) * MAX_SYMBOLS + int'(col_index))] <=
							(prob_value > ONE_Q15) ? ONE_Q15 : prob_value;
				FUNC_LOAD_SYM:
					if (5'(col_index) < nsym) sym_q[YW'(col_index)] <= char_code;
				default: ;
			endcase
		end
		if (state_q == ST_RD) begin
			trans_s1 <= trans_mem[TW'(int'(k_q) * MAX_STATES + int'(j_q))];
			emit_s1  <= emit_mem[EW'(int'(j_q) * MAX_SYMBOLS + int'(s_q))];
			init_s1  <= init_mem[j_q[SW-1:0]];
			alpha_s1 <= alpha_q[k_q[SW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			state_count_q  <= 5'd2;
			symbol_count_q <= 5'd4;
			obs_q          <= '0;
			j_q <= '0; k_q <= '0; s_q <= '0;
			first_q <= 1'b0;
			sum_q <= '0;
			done <= 1'b0; status <= STATUS_OK; total_prob <= '0; obs_count <= '0;
			func_q <= '0; row_q <= '0; col_q <= '0; char_q <= '0;
			for (int i = 0; i < MAX_STATES; i++) begin
				alpha_q[i] <= '0;
				next_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			done <= (state_q == ST_DONE);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_STATE_COUNT) state_count_q <= cfg_data;
				else symbol_count_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: if (start) begin
					func_q <= func; row_q <= row_index; col_q <= col_index;
					char_q <= char_code;
					s_q <= '0; j_q <= '0; k_q <= '0; sum_q <= '0;
					first_q <= (obs_q == 16'd0);
				end
				ST_SEARCH:
					if (s_q < 6'(nsym) && sym_q[s_q[YW-1:0]] != char_q) s_q <= s_q + 6'd1;
				ST_J_START: k_q <= '0;
				ST_ACC: if (!last_k) k_q <= k_q + 6'd1;
				ST_WRITE: begin
					next_q[j_q[SW-1:0]] <= acc;
					j_q <= j_q + 6'd1;
				end
				ST_COPY: begin
					for (int i = 0; i < MAX_STATES; i++)
						alpha_q[i] <= (i < int'(ns)) ? next_q[i] : 32'd0;
					if (obs_q != 16'hFFFF) obs_q <= obs_q + 16'd1;
				end
				ST_SUM: if (k_q < 6'(ns)) begin
					sum_q <= sat_add(sum_q, alpha_q[k_q[SW-1:0]]);
					k_q <= k_q + 6'd1;
				end
				ST_DONE: begin
					status <= done_status;
					obs_count <= obs_q;
					total_prob <= (func_q == FUNC_FINISH) ? sum_q : 32'd0;
					// finish restarts the sequence
					if (func_q == FUNC_FINISH) begin
						obs_q <= '0;
						for (int i = 0; i < MAX_STATES; i++) alpha_q[i] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### tb/sv/tb_hmm_forward_probability_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hmm forward probability testbench
// fills every table between directed runs, then runs random requests over several
// state and symbol counts; results are checked against fixed values or a local forward model
// ---------------------------------------------------------------------------
module tb_hmm_forward_probability_top;
	import hmm_pkg::*;

	typedef struct {
		logic [1:0]  st;
		logic [31:0] total;
		logic [15:0] cnt;
	} hmm_result_t;

	typedef struct {
		logic [2:0]  fn;
		logic [3:0]  row;
		logic [3:0]  col;
		logic [15:0] prob;
		logic [7:0]  ch;
		bit          typed;
		hmm_result_t res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  func = '0;
	logic [3:0]  row_index = '0;
	logic [3:0]  col_index = '0;
	logic [15:0] prob_value = '0;
	logic [7:0]  char_code = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [4:0]  cfg_data = '0;
	logic        done;
	logic [1:0]  status;
	logic [31:0] total_prob;
	logic [15:0] obs_count;

	hmm_forward_probability_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .row_index(row_index), .col_index(col_index),
		.prob_value(prob_value), .char_code(char_code),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .status(status),
		.total_prob(total_prob), .obs_count(obs_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// local copy of the block state
	logic [4:0]  m_states;
	logic [4:0]  m_symbols;
	logic [15:0] m_pi [16];
	logic [15:0] m_trans [256];
	logic [15:0] m_emit [256];
	logic [7:0]  m_sym [16];
	logic [31:0] m_alpha [16];
	logic [15:0] m_seen;

	hmm_result_t pending_results[$];
	int          fail_count = 0;
	bit          no_gaps = 0;

	logic [4:0] ns_set [] = '{5'd2, 5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd5, 5'd1, 5'd4};
	logic [4:0] sy_set [] = '{5'd4, 5'd1, 5'd16, 5'd5, 5'd31, 5'd2, 5'd8, 5'd16, 5'd0};

	function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > 33'h0_8000_0000) ? 32'h8000_0000 : s[31:0];
	endfunction

	function automatic hmm_result_t forward_step(logic [2:0] fn, logic [3:0] row,
			logic [3:0] col, logic [15:0] prob_in, logic [7:0] ch);
		hmm_result_t r;
		int          ns, nsym, s;
		logic [15:0] p;
		logic [31:0] nxt [16];
		logic [63:0] t, e;
		bit          found;
		ns = (m_states > 16) ? 16 : m_states;
		nsym = (m_symbols > 16) ? 16 : m_symbols;
		p = (prob_in > ONE_Q15) ? ONE_Q15 : prob_in;
		r.st = STATUS_OK;
		r.total = '0;
		found = 0;
		s = 0;
		case (fn)
			FUNC_LOAD_INIT: begin
				if (row < ns) m_pi[row] = p; else r.st = STATUS_RANGE;
			end
			FUNC_LOAD_TRANS: begin
				if (row < ns && col < ns) m_trans[row*16+col] = p; else r.st = STATUS_RANGE;
			end
			FUNC_LOAD_EMIT: begin
				if (row < ns && col < nsym) m_emit[row*16+col] = p; else r.st = STATUS_RANGE;
			end
			FUNC_LOAD_SYM: begin
				if (col < nsym) m_sym[col] = ch; else r.st = STATUS_RANGE;
			end
			FUNC_OBSERVE: begin
				for (int i = 0; i < nsym; i++)
					if (!found && m_sym[i] == ch) begin
						found = 1;
						s = i;
					end
				if (!found) begin
					r.st = STATUS_UNKNOWN;
				end else begin
					for (int j = 0; j < 16; j++) begin
						nxt[j] = '0;
						if (j < ns) begin
							e = m_emit[j*16+s];
							if (m_seen == 0) begin
								t = (m_pi[j] * e) << 1;
								nxt[j] = t[31:0];
							end else begin
								for (int k = 0; k < ns; k++) begin
									t = (m_alpha[k] * 64'(m_trans[k*16+j])) >> 15;
									t = (t * e) >> 15;
									if (t > 64'h8000_0000) t = 64'h8000_0000;
									nxt[j] = add_sat(nxt[j], t[31:0]);
								end
							end
						end
					end
					m_alpha = nxt;
					if (m_seen != 16'hFFFF) m_seen++;
				end
			end
			FUNC_FINISH: begin
				for (int j = 0; j < ns; j++) r.total = add_sat(r.total, m_alpha[j]);
				r.cnt = m_seen;
				foreach (m_alpha[j]) m_alpha[j] = '0;
				m_seen = '0;
				return r;
			end
			default: r.st = STATUS_RANGE;
		endcase
		r.cnt = m_seen;
		return r;
	endfunction

	task automatic idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 65) return;
		repeat (r < 95 ? $urandom_range(1, 4) : $urandom_range(10, 40)) @(negedge clk);
	endtask

	// drive one request, record its expected result at the accepting edge
	task automatic send_req(stim_row_t sr);
		hmm_result_t pred;
		idle_gap();
		start = 1'b1;
		func = sr.fn;
		row_index = sr.row;
		col_index = sr.col;
		prob_value = sr.prob;
		char_code = sr.ch;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		pred = forward_step(sr.fn, sr.row, sr.col, sr.prob, sr.ch);
		pending_results.push_back(sr.typed ? sr.res : pred);
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic send_plain(logic [2:0] fn, logic [3:0] row, logic [3:0] col,
			logic [15:0] prob, logic [7:0] ch);
		stim_row_t sr;
		sr.fn = fn; sr.row = row; sr.col = col; sr.prob = prob; sr.ch = ch;
		sr.typed = 0;
		send_req(sr);
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [4:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		if (idx == REG_STATE_COUNT) m_states = val; else m_symbols = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic stim_row_t random_req();
		stim_row_t sr;
		int        r, nsym;
		nsym = (m_symbols > 16) ? 16 : m_symbols;
		r = $urandom_range(0, 99);
		sr.typed = 0;
		sr.row = 4'($urandom_range(0, 15));
		sr.col = 4'($urandom_range(0, 15));
		sr.prob = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
		sr.ch = 8'($urandom);
		if (r < 50) begin
			sr.fn = FUNC_OBSERVE;
			if (nsym > 0 && $urandom_range(0, 9) < 8) sr.ch = m_sym[$urandom_range(0, nsym-1)];
		end else if (r < 62) begin
			sr.fn = FUNC_FINISH;
		end else if (r < 96) begin
			sr.fn = 3'($urandom_range(FUNC_LOAD_INIT, FUNC_LOAD_SYM));
		end else begin
			sr.fn = 3'($urandom_range(6, 7));
		end
		return sr;
	endfunction

	always @(posedge clk) begin
		hmm_result_t x;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no request pending");
				fail_count++;
			end else begin
				x = pending_results.pop_front();
				if (status !== x.st) begin
					$error("status exp %0d got %0d", x.st, status);
					fail_count++;
				end
				if (total_prob !== x.total) begin
					$error("total_prob exp %0h got %0h", x.total, total_prob);
					fail_count++;
				end
				if (obs_count !== x.cnt) begin
					$error("obs_count exp %0d got %0d", x.cnt, obs_count);
					fail_count++;
				end
			end
		end
	end

	stim_row_t directed[] = '{
		// empty sequence after reset
		'{FUNC_FINISH, 4'd0, 4'd0, 16'd0, 8'd0, 1, '{STATUS_OK, 32'd0, 16'd0}},
		'{3'd6, 4'd0, 4'd0, 16'd0, 8'd0, 1, '{STATUS_RANGE, 32'd0, 16'd0}},
		'{3'd7, 4'd15, 4'd15, 16'hFFFF, 8'hFF, 1, '{STATUS_RANGE, 32'd0, 16'd0}},
		'{FUNC_LOAD_INIT, 4'd15, 4'd0, 16'd1, 8'd0, 1, '{STATUS_RANGE, 32'd0, 16'd0}},
		'{FUNC_LOAD_TRANS, 4'd0, 4'd2, 16'd1, 8'd0, 1, '{STATUS_RANGE, 32'd0, 16'd0}},
		'{FUNC_LOAD_EMIT, 4'd1, 4'd4, 16'd1, 8'd0, 1, '{STATUS_RANGE, 32'd0, 16'd0}},
		'{FUNC_LOAD_SYM, 4'd0, 4'd15, 16'd0, 8'hFF, 1, '{STATUS_RANGE, 32'd0, 16'd0}},
		'{FUNC_LOAD_INIT, 4'd0, 4'd0, 16'hFFFF, 8'd0, 1, '{STATUS_OK, 32'd0, 16'd0}},
		'{FUNC_LOAD_INIT, 4'd1, 4'd0, 16'h8000, 8'd0, 1, '{STATUS_OK, 32'd0, 16'd0}}
	};

	// directed observes, run once every table holds known values
	stim_row_t obs_rows[] = '{
		'{FUNC_OBSERVE, 4'd0, 4'd0, 16'd0, 8'h41, 0, '{STATUS_OK, 32'd0, 16'd0}},
		'{FUNC_OBSERVE, 4'd0, 4'd0, 16'd0, 8'h00, 0, '{STATUS_OK, 32'd0, 16'd0}},
		'{FUNC_OBSERVE, 4'd0, 4'd0, 16'd0, 8'h43, 0, '{STATUS_OK, 32'd0, 16'd0}},
		'{FUNC_FINISH, 4'd0, 4'd0, 16'd0, 8'd0, 0, '{STATUS_OK, 32'd0, 16'd0}},
		// duplicate symbol takes lowest index
		'{FUNC_LOAD_SYM, 4'd0, 4'd3, 16'd0, 8'h41, 0, '{STATUS_OK, 32'd0, 16'd0}},
		'{FUNC_OBSERVE, 4'd0, 4'd0, 16'd0, 8'h41, 0, '{STATUS_OK, 32'd0, 16'd0}},
		'{FUNC_OBSERVE, 4'd0, 4'd0, 16'd0, 8'h41, 0, '{STATUS_OK, 32'd0, 16'd0}},
		'{FUNC_FINISH, 4'd0, 4'd0, 16'd0, 8'd0, 0, '{STATUS_OK, 32'd0, 16'd0}}
	};

	initial begin
		int n_items;
		m_states = 5'd2;
		m_symbols = 5'd4;
		m_seen = '0;
		foreach (m_alpha[j]) m_alpha[j] = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) send_req(directed[i]);
		drain();

		// fill every table entry at full size so nothing unwritten is ever read
		write_reg(REG_STATE_COUNT, 5'd16);
		write_reg(REG_SYMBOL_COUNT, 5'd16);
		no_gaps = 1;
		for (int i = 0; i < 16; i++) begin
			send_plain(FUNC_LOAD_INIT, 4'(i), 4'd0, 16'($urandom_range(0, 32768)), 8'd0);
			send_plain(FUNC_LOAD_SYM, 4'd0, 4'(i), 16'd0, 8'(8'h41 + i));
			for (int j = 0; j < 16; j++) begin
				send_plain(FUNC_LOAD_TRANS, 4'(i), 4'(j), 16'($urandom_range(0, 32768)), 8'd0);
				send_plain(FUNC_LOAD_EMIT, 4'(i), 4'(j), 16'($urandom_range(0, 32768)), 8'd0);
			end
		end
		no_gaps = 0;
		drain();
		write_reg(REG_STATE_COUNT, 5'd2);
		write_reg(REG_SYMBOL_COUNT, 5'd4);
		// ones in the init and transition entries and in the third symbol's emission column drive the sums toward saturation
		send_plain(FUNC_LOAD_INIT, 4'd0, 4'd0, 16'h8000, 8'd0);
		send_plain(FUNC_LOAD_INIT, 4'd1, 4'd0, 16'h8000, 8'd0);
		for (int i = 0; i < 2; i++) begin
			send_plain(FUNC_LOAD_EMIT, 4'(i), 4'd2, 16'h8000, 8'd0);
			for (int j = 0; j < 2; j++) send_plain(FUNC_LOAD_TRANS, 4'(i), 4'(j), 16'h8000, 8'd0);
		end
		foreach (obs_rows[i]) send_req(obs_rows[i]);
		drain();

		foreach (ns_set[p]) begin
			write_reg(REG_STATE_COUNT, ns_set[p]);
			write_reg(REG_SYMBOL_COUNT, sy_set[p]);
			no_gaps = (p % 3 == 1);
			n_items = (ns_set[p] >= 16) ? 8 : 14;
			repeat (n_items) send_req(random_req());
			drain();
		end
		for (int p = 0; p < 2; p++) begin
			write_reg(REG_STATE_COUNT, 5'($urandom_range(1, 6)));
			write_reg(REG_SYMBOL_COUNT, 5'($urandom_range(1, 16)));
			repeat (10) send_req(random_req());
			drain();
		end

		while (pending_results.size() != 0) @(negedge clk);
		repeat (1200) @(negedge clk);
		if (fail_count == 0)
			$display("tb_hmm_forward_probability_top: PASS");
		else
			$display("tb_hmm_forward_probability_top: FAIL");
		$finish;
	end

	initial begin
		#200ms;
		$display("tb_hmm_forward_probability_top: FAIL");
		$finish;
	end

endmodule

### hmm_forward_probability_top.f
design/hmm_pkg.sv
design/hmm_mac.sv
design/hmm_forward_probability_top.sv
tb/sv/tb_hmm_forward_probability_top.sv
